// File: design/kdr_pkg.sv
`timescale 1ns / 1ps

package kdr_pkg;

    // Key table size and derived widths
    localparam int KEY_COUNT = 64;
    localparam int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    // Fixed field widths
    localparam int INDEX_W = 6;
    localparam int CLASS_W = 2;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;

    // Range check limit, wide enough for any key count up to 256
    localparam logic [8:0] KEY_LIMIT = 9'(KEY_COUNT);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Key classes that select a repeat interval; all other codes are ordinary
    localparam logic [CLASS_W-1:0] CLASS_QUICK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_POINTER = 2'd2;

    // Register reset values
    localparam logic [DELAY_W-1:0] DEBOUNCE_RESET       = 16'd50;
    localparam logic [DELAY_W-1:0] REPEAT_RESET         = 16'd300;
    localparam logic [DELAY_W-1:0] REPEAT_QUICK_RESET   = 16'd150;
    localparam logic [DELAY_W-1:0] REPEAT_POINTER_RESET = 16'd30;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE       = 2'd0,
        CFG_REPEAT         = 2'd1,
        CFG_REPEAT_QUICK   = 2'd2,
        CFG_REPEAT_POINTER = 2'd3
    } kdr_cfg_index_t;

    typedef enum logic {
        OP_KEY      = 1'b0,
        OP_SCAN_END = 1'b1
    } kdr_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_SWEEP,
        ST_DRAIN
    } kdr_state_t;

    typedef struct packed {
        kdr_op_t             op;
        logic [KEY_W-1:0]    key;
        logic [CLASS_W-1:0]  cls;
        logic [TIME_W-1:0]   stamp;
    } kdr_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] first_seen;
        logic [TIME_W-1:0] last_seen;
        logic [TIME_W-1:0] last_sent;
    } kdr_times_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kdr_q_stat_t;

endpackage

// File: design/kdr_ram.sv
`timescale 1ns / 1ps

module kdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/kdr_front.sv
`timescale 1ns / 1ps

module kdr_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [kdr_pkg::INDEX_W-1:0]   key_index,
    input  logic [kdr_pkg::CLASS_W-1:0]   key_class,
    input  logic [kdr_pkg::TIME_W-1:0]    scan_time,
    input  kdr_pkg::kdr_q_stat_t          q_stat,
    output logic                          push,
    output kdr_pkg::kdr_item_t            push_item
);

    logic in_range;
    logic accept;

    // drop key words outside the table: accepted, but never queued
    assign in_range = {3'b000, key_index} < kdr_pkg::KEY_LIMIT;
    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign push     = accept && (cmd || in_range);

    always_comb
    begin
        push_item.op    = cmd ? kdr_pkg::OP_SCAN_END : kdr_pkg::OP_KEY;
        push_item.key   = kdr_pkg::KEY_W'(key_index);
        push_item.cls   = key_class;
        push_item.stamp = scan_time;
    end

endmodule

// File: design/kdr_queue.sv
`timescale 1ns / 1ps

module kdr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  kdr_pkg::kdr_item_t    push_item,
    input  logic                  pop,
    output kdr_pkg::kdr_item_t    head,
    output kdr_pkg::kdr_q_stat_t  q_stat
);

    kdr_pkg::kdr_item_t                slot_reg [kdr_pkg::QUEUE_DEPTH];
    logic [kdr_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [kdr_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [kdr_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              do_push, do_pop;

    assign q_stat.full  = count_reg == kdr_pkg::QCNT_W'(kdr_pkg::QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = slot_reg[rd_ptr_reg];

    function automatic logic [kdr_pkg::QPTR_W-1:0] ptr_inc(
        input logic [kdr_pkg::QPTR_W-1:0] p
    );
        if (p == kdr_pkg::QPTR_W'(kdr_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/kdr_back.sv
`timescale 1ns / 1ps

module kdr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kdr_pkg::kdr_q_stat_t          q_stat,
    input  kdr_pkg::kdr_item_t            head,
    output logic                          pop,
    input  logic                          cfg_wr_en,
    input  kdr_pkg::kdr_cfg_index_t       cfg_index,
    input  logic [kdr_pkg::DELAY_W-1:0]   cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kdr_pkg::INDEX_W-1:0]   emit_key
);

    kdr_pkg::kdr_state_t               state_reg, state_next;
    kdr_pkg::kdr_item_t                cur_reg;
    logic [kdr_pkg::KEY_COUNT-1:0]     held_reg, held_next;
    logic [kdr_pkg::KEY_COUNT-1:0]     sent_once_reg, sent_once_next;
    logic                              scan_has_keys_reg;
    logic [kdr_pkg::KEY_W-1:0]         sweep_cnt_reg;
    logic                              chk_vld_reg;
    logic [kdr_pkg::KEY_W-1:0]         chk_idx_reg;
    logic                              out_valid_reg;
    logic [kdr_pkg::INDEX_W-1:0]       emit_key_reg;
    logic [kdr_pkg::DELAY_W-1:0]       debounce_reg;
    logic [kdr_pkg::DELAY_W-1:0]       repeat_reg;
    logic [kdr_pkg::DELAY_W-1:0]       repeat_quick_reg;
    logic [kdr_pkg::DELAY_W-1:0]       repeat_pointer_reg;

    logic [kdr_pkg::KEY_W-1:0]         rd_addr;
    logic                              wr_en;
    kdr_pkg::kdr_times_t               wr_data;
    kdr_pkg::kdr_times_t               rd_data;

    logic                              slot_held;
    logic                              slot_once;
    logic [kdr_pkg::TIME_W-1:0]        first_t, sent_t;
    logic [kdr_pkg::TIME_W-1:0]        hold_time, since_sent;
    logic [kdr_pkg::DELAY_W-1:0]       interval;
    logic                              fire;
    logic                              out_free;
    logic                              key_go;
    logic                              sweep_last;
    logic                              scan_end_pop;

    kdr_ram #(
        .WIDTH ($bits(kdr_pkg::kdr_times_t)),
        .DEPTH (kdr_pkg::KEY_COUNT)
    ) u_times (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_reg.key),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // key update: stored times only count while the key is held
    always_comb
    begin
        slot_held  = held_reg[cur_reg.key];
        slot_once  = slot_held && sent_once_reg[cur_reg.key];
        first_t    = slot_held ? rd_data.first_seen : cur_reg.stamp;
        sent_t     = slot_held ? rd_data.last_sent : '0;
        hold_time  = cur_reg.stamp - first_t;
        since_sent = cur_reg.stamp - sent_t;
        if (cur_reg.cls == kdr_pkg::CLASS_QUICK)
        begin
            interval = repeat_quick_reg;
        end
        else if (cur_reg.cls == kdr_pkg::CLASS_POINTER)
        begin
            interval = repeat_pointer_reg;
        end
        else
        begin
            interval = repeat_reg;
        end
        fire = (hold_time > {16'd0, debounce_reg})
            && (!slot_once || (since_sent > {16'd0, interval}));
    end

    assign out_free     = !out_valid_reg || !out_stall;
    assign key_go       = (state_reg == kdr_pkg::ST_KEY) && (!fire || out_free);
    assign sweep_last   = sweep_cnt_reg == kdr_pkg::KEY_W'(kdr_pkg::KEY_COUNT - 1);
    assign pop          = (state_reg == kdr_pkg::ST_IDLE) && !q_stat.empty;
    assign scan_end_pop = pop && (head.op == kdr_pkg::OP_SCAN_END);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kdr_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    if (head.op == kdr_pkg::OP_KEY)
                    begin
                        state_next = kdr_pkg::ST_KEY;
                    end
                    else if (scan_has_keys_reg)
                    begin
                        state_next = kdr_pkg::ST_SWEEP;
                    end
                end
            end
            kdr_pkg::ST_KEY:
            begin
                if (key_go)
                begin
                    state_next = kdr_pkg::ST_IDLE;
                end
            end
            kdr_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = kdr_pkg::ST_DRAIN;
                end
            end
            kdr_pkg::ST_DRAIN:
            begin
                state_next = kdr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kdr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: memory port controls
    always_comb
    begin
        rd_addr = cur_reg.key;
        unique case (state_reg)
            kdr_pkg::ST_IDLE:  rd_addr = head.key;
            kdr_pkg::ST_KEY:   rd_addr = cur_reg.key;
            kdr_pkg::ST_SWEEP: rd_addr = sweep_cnt_reg;
            kdr_pkg::ST_DRAIN: rd_addr = cur_reg.key;
            default:           rd_addr = cur_reg.key;
        endcase
        wr_en              = key_go;
        wr_data.first_seen = first_t;
        wr_data.last_seen  = cur_reg.stamp;
        wr_data.last_sent  = fire ? cur_reg.stamp : sent_t;
    end

    // flag updates
    always_comb
    begin
        held_next      = held_reg;
        sent_once_next = sent_once_reg;
        if (key_go)
        begin
            held_next[cur_reg.key]      = 1'b1;
            sent_once_next[cur_reg.key] = slot_once || fire;
        end
        if (chk_vld_reg && (rd_data.last_seen != cur_reg.stamp))
        begin
            held_next[chk_idx_reg]      = 1'b0;
            sent_once_next[chk_idx_reg] = 1'b0;
        end
        if (scan_end_pop && !scan_has_keys_reg)
        begin
            held_next      = '0;
            sent_once_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= kdr_pkg::ST_IDLE;
            held_reg           <= '0;
            sent_once_reg      <= '0;
            scan_has_keys_reg  <= 1'b0;
            sweep_cnt_reg      <= '0;
            chk_vld_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
            debounce_reg       <= kdr_pkg::DEBOUNCE_RESET;
            repeat_reg         <= kdr_pkg::REPEAT_RESET;
            repeat_quick_reg   <= kdr_pkg::REPEAT_QUICK_RESET;
            repeat_pointer_reg <= kdr_pkg::REPEAT_POINTER_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            sent_once_reg <= sent_once_next;
            chk_vld_reg   <= state_reg == kdr_pkg::ST_SWEEP;
            if (key_go)
            begin
                scan_has_keys_reg <= 1'b1;
            end
            else if (state_reg == kdr_pkg::ST_DRAIN)
            begin
                scan_has_keys_reg <= 1'b0;
            end
            if (scan_end_pop)
            begin
                sweep_cnt_reg <= '0;
            end
            else if (state_reg == kdr_pkg::ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (key_go && fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    kdr_pkg::CFG_DEBOUNCE:       debounce_reg       <= cfg_data;
                    kdr_pkg::CFG_REPEAT:         repeat_reg         <= cfg_data;
                    kdr_pkg::CFG_REPEAT_QUICK:   repeat_quick_reg   <= cfg_data;
                    kdr_pkg::CFG_REPEAT_POINTER: repeat_pointer_reg <= cfg_data;
                    default:                     debounce_reg       <= debounce_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        chk_idx_reg <= sweep_cnt_reg;
        if (key_go && fire)
        begin
            emit_key_reg <= kdr_pkg::INDEX_W'(cur_reg.key);
        end
    end

    assign out_valid = out_valid_reg;
    assign emit_key  = emit_key_reg;

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kdr_pkg::ST_SWEEP)
            |-> (sweep_cnt_reg <= kdr_pkg::KEY_W'(kdr_pkg::KEY_COUNT - 1)))
        else $error("sweep counter ran past the key table");

    a_empty_scan_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_end_pop && !scan_has_keys_reg) |=> (held_reg == '0))
        else $error("empty scan left a key held");

    a_sent_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((sent_once_reg & ~held_reg) == '0))
        else $error("sent flag set on a released key");

    a_emit_from_key: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == kdr_pkg::ST_KEY))
        else $error("result raised outside a key update");

endmodule

// File: design/key_debounce_repeat_tracker.sv
`timescale 1ns / 1ps

// Keyboard debounce and typematic repeat tracker. Feed one word per key seen
// in a scan (cmd 0) and one end-of-scan word (cmd 1) after each scan; a key
// word yields at most one emit_key word, once the key has been held longer
// than the debounce delay and then whenever its class's repeat interval has
// passed. Input words go into a two-word queue and are worked off one at a
// time. In the back end a key word is dispatched, then the key's times get
// a read-modify-write through the registered read port of the time memory;
// a key word that emits waits while out_stall holds the previous result.
// An end-of-scan word clears every held key when no key arrived in that
// scan; otherwise a sweep reads each key's last-seen time through the
// memory's single read port, one key a cycle, and releases held keys not
// seen at that scan time. Key indexes at or beyond KEY_COUNT are accepted
// and dropped. Write the delay registers only while the block is idle.

module key_debounce_repeat_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [kdr_pkg::INDEX_W-1:0]   key_index,
    input  logic [kdr_pkg::CLASS_W-1:0]   key_class,
    input  logic [kdr_pkg::TIME_W-1:0]    scan_time,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kdr_pkg::INDEX_W-1:0]   emit_key,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [kdr_pkg::DELAY_W-1:0]   cfg_data
);

    kdr_pkg::kdr_q_stat_t q_stat;
    kdr_pkg::kdr_item_t   push_item;
    kdr_pkg::kdr_item_t   head;
    logic                 push;
    logic                 pop;

    // classify incoming words and drop out-of-range keys
    kdr_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key_index (key_index),
        .key_class (key_class),
        .scan_time (scan_time),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    // hold classified words until the back end is free
    kdr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // carry out key updates and end-of-scan sweeps, drive the result register
    kdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (kdr_pkg::kdr_cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .emit_key  (emit_key)
    );

endmodule
